FILE: sv/assert_macros.svh
// Assertion helpers shared by the square root, divide and top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define KBC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define KBC_ASSERT(lbl, clk, rstn, prop)
`define KBC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: sv/kbc_pkg.sv
package kbc_pkg;

  // fixed field widths
  localparam int POS_W = 48;
  localparam int ROT_W = 64;
  localparam int SCL_W = 48;
  localparam int T_W   = 16;
  localparam int ROW_W = 64;

  // widest lane the fields allow, and datapath widths sized for it
  localparam int LW    = 16;
  localparam int BW    = LW + 2;          // blended value
  localparam int N2W   = 2 * (LW + 1) - 1 + 2;  // sum of four squares
  localparam int RFRAC = 28;              // norm radicand shift
  localparam int RTW   = (N2W + RFRAC + 1) / 2; // square root width
  localparam int RMW   = RTW + 2;         // square root remainder
  localparam int QUW   = 16;              // quotient bits
  localparam int UQW   = QUW + 1;         // signed unit component

  localparam logic [T_W-1:0] T_ONE   = 16'h8000;
  localparam int             Q14_ONE = 16384;

  typedef logic signed [LW-1:0]  lane_t;
  typedef logic signed [BW-1:0]  bval_t;
  typedef logic signed [UQW-1:0] uq_t;

  typedef struct packed {
    bval_t [2:0] pos;
    bval_t [2:0] scl;
  } side_t;

  typedef struct packed {
    side_t            side;
    bval_t [3:0]      q;
    logic [N2W-1:0]   n2;
  } nrm_in_t;

  typedef struct packed {
    side_t            side;
    bval_t [3:0]      q;
    logic             degen;
    logic [RTW-1:0]   nrm;
  } div_in_t;

  typedef struct packed {
    side_t      side;
    uq_t [3:0]  uq;
    logic       degen;
  } cmp_in_t;

endpackage

FILE: sv/kbc_blend.sv
module kbc_blend #(
  parameter int CW = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ce_i,
  input  logic                       vld_i,
  input  logic [kbc_pkg::POS_W-1:0]  pos_a_i,
  input  logic [kbc_pkg::POS_W-1:0]  pos_b_i,
  input  logic [kbc_pkg::ROT_W-1:0]  rot_a_i,
  input  logic [kbc_pkg::ROT_W-1:0]  rot_b_i,
  input  logic [kbc_pkg::SCL_W-1:0]  scale_a_i,
  input  logic [kbc_pkg::SCL_W-1:0]  scale_b_i,
  input  logic [kbc_pkg::T_W-1:0]    blend_t_i,
  output logic                       vld_o,
  output kbc_pkg::nrm_in_t           data_o
);

  localparam int TW  = kbc_pkg::T_W;
  localparam int N2W = kbc_pkg::N2W;

  kbc_pkg::lane_t pa_w [3];
  kbc_pkg::lane_t pb_w [3];
  kbc_pkg::lane_t sa_w [3];
  kbc_pkg::lane_t sb_w [3];
  kbc_pkg::lane_t qa_w [4];
  kbc_pkg::lane_t qb_w [4];

  // stage A: lanes and clamped factor
  kbc_pkg::lane_t pa_q [3];
  kbc_pkg::lane_t pb_q [3];
  kbc_pkg::lane_t sa_q [3];
  kbc_pkg::lane_t sb_q [3];
  kbc_pkg::lane_t qa_q [4];
  kbc_pkg::lane_t qb_q [4];
  logic [TW-1:0]  t_q;
  logic [TW-1:0]  t_d;

  // stage B: products
  logic signed [31:0] dp_d [4];
  logic signed [31:0] dp_q [4];
  logic signed [32:0] pd_d [3];
  logic signed [32:0] pd_q [3];
  logic signed [32:0] sd_d [3];
  logic signed [32:0] sd_q [3];
  kbc_pkg::lane_t     pa_b_q [3];
  kbc_pkg::lane_t     sa_b_q [3];
  kbc_pkg::lane_t     qa_b_q [4];
  kbc_pkg::lane_t     qb_b_q [4];
  logic [TW-1:0]      t_b_q;

  // stage C: sign fix, position and scale done
  logic signed [33:0] dot_w;
  kbc_pkg::side_t     side_c_d;
  kbc_pkg::side_t     side_c_q;
  logic signed [16:0] qn_d [4];
  logic signed [16:0] qn_c_q [4];
  logic signed [17:0] qd_d [4];
  logic signed [17:0] qd_c_q [4];
  logic [TW-1:0]      t_c_q;

  // stage D: quaternion lerp products
  kbc_pkg::side_t     side_d_q;
  logic signed [16:0] qn_d_q [4];
  logic signed [34:0] qt_d [4];
  logic signed [34:0] qt_d_q [4];

  // stage E: blended quaternion
  kbc_pkg::side_t     side_e_q;
  kbc_pkg::bval_t     q_d [4];
  kbc_pkg::bval_t     q_e_q [4];

  // stage F: squares
  kbc_pkg::side_t     side_f_q;
  kbc_pkg::bval_t     q_f_q [4];
  logic signed [35:0] sqf_w [4];
  logic [30:0]        sq_f_q [4];

  // stage G: squared norm
  kbc_pkg::nrm_in_t   out_d;
  kbc_pkg::nrm_in_t   out_q;

  logic [6:0] vld_q;

  for (genvar k = 0; k < 3; k++) begin : g_lane3
    assign pa_w[k] = kbc_pkg::lane_t'($signed(pos_a_i[k*CW +: CW]));
    assign pb_w[k] = kbc_pkg::lane_t'($signed(pos_b_i[k*CW +: CW]));
    assign sa_w[k] = kbc_pkg::lane_t'($signed(scale_a_i[k*CW +: CW]));
    assign sb_w[k] = kbc_pkg::lane_t'($signed(scale_b_i[k*CW +: CW]));
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane4
    assign qa_w[k] = kbc_pkg::lane_t'($signed(rot_a_i[k*CW +: CW]));
    assign qb_w[k] = kbc_pkg::lane_t'($signed(rot_b_i[k*CW +: CW]));
  end

  assign t_d = (blend_t_i > kbc_pkg::T_ONE) ? kbc_pkg::T_ONE : blend_t_i;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dp_d[k] = qa_q[k] * qb_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      pd_d[k] = (17'(pb_q[k]) - 17'(pa_q[k])) * $signed({1'b0, t_q});
      sd_d[k] = (17'(sb_q[k]) - 17'(sa_q[k])) * $signed({1'b0, t_q});
    end
  end

  // negative dot: flip the first key, round the lerps half up
  always_comb begin
    dot_w = 34'(dp_q[0]) + 34'(dp_q[1]) + 34'(dp_q[2]) + 34'(dp_q[3]);
    for (int k = 0; k < 4; k++) begin
      qn_d[k] = dot_w[33] ? -17'(qa_b_q[k]) : 17'(qa_b_q[k]);
      qd_d[k] = 18'(qb_b_q[k]) - 18'(qn_d[k]);
    end
    for (int k = 0; k < 3; k++) begin
      side_c_d.pos[k] = 18'(pa_b_q[k]) + 18'((pd_q[k] + 33'sd16384) >>> 15);
      side_c_d.scl[k] = 18'(sa_b_q[k]) + 18'((sd_q[k] + 33'sd16384) >>> 15);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qt_d[k]  = qd_c_q[k] * $signed({1'b0, t_c_q});
      q_d[k]   = 18'(qn_d_q[k]) + 18'((qt_d_q[k] + 35'sd16384) >>> 15);
      sqf_w[k] = q_e_q[k] * q_e_q[k];
    end
  end

  always_comb begin
    out_d.side = side_f_q;
    for (int k = 0; k < 4; k++) begin
      out_d.q[k] = q_f_q[k];
    end
    out_d.n2 = N2W'(sq_f_q[0]) + N2W'(sq_f_q[1]) + N2W'(sq_f_q[2]) + N2W'(sq_f_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      pa_q     <= pa_w;
      pb_q     <= pb_w;
      sa_q     <= sa_w;
      sb_q     <= sb_w;
      qa_q     <= qa_w;
      qb_q     <= qb_w;
      t_q      <= t_d;
      dp_q     <= dp_d;
      pd_q     <= pd_d;
      sd_q     <= sd_d;
      pa_b_q   <= pa_q;
      sa_b_q   <= sa_q;
      qa_b_q   <= qa_q;
      qb_b_q   <= qb_q;
      t_b_q    <= t_q;
      side_c_q <= side_c_d;
      qn_c_q   <= qn_d;
      qd_c_q   <= qd_d;
      t_c_q    <= t_b_q;
      side_d_q <= side_c_q;
      qn_d_q   <= qn_c_q;
      qt_d_q   <= qt_d;
      side_e_q <= side_d_q;
      q_e_q    <= q_d;
      side_f_q <= side_e_q;
      q_f_q    <= q_e_q;
      for (int k = 0; k < 4; k++) begin
        sq_f_q[k] <= sqf_w[k][30:0];
      end
      out_q    <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  assign vld_o  = vld_q[6];
  assign data_o = out_q;

endmodule

FILE: sv/kbc_isqrt.sv
`include "assert_macros.svh"

module kbc_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ce_i,
  input  logic              vld_i,
  input  kbc_pkg::nrm_in_t  data_i,
  output logic              vld_o,
  output kbc_pkg::div_in_t  data_o
);

  localparam int N2W   = kbc_pkg::N2W;
  localparam int RTW   = kbc_pkg::RTW;
  localparam int RMW   = kbc_pkg::RMW;
  localparam int RFRAC = kbc_pkg::RFRAC;
  localparam int NSTG  = RTW;
  localparam int NFW   = 2 * RTW;

  typedef struct packed {
    kbc_pkg::side_t         side;
    kbc_pkg::bval_t [3:0]   q;
    logic [N2W-1:0]         n2;
    logic [RTW-1:0]         root;
    logic [RMW-1:0]         rem;
  } sq_stage_t;

  sq_stage_t       init_w;
  sq_stage_t       st_q [NSTG];
  logic [NSTG-1:0] vld_q;

  always_comb begin
    init_w      = '0;
    init_w.side = data_i.side;
    init_w.q    = data_i.q;
    init_w.n2   = data_i.n2;
  end

  // one radicand digit pair per stage, most significant first
  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    sq_stage_t      prv;
    sq_stage_t      nxt;
    logic [NFW-1:0] nf;
    logic [RMW+1:0] cur;
    logic [RMW+1:0] trial;

    if (k == 0) begin : g_first
      assign prv = init_w;
    end else begin : g_next
      assign prv = st_q[k-1];
    end

    assign nf    = NFW'({prv.n2, {RFRAC{1'b0}}});
    assign cur   = {prv.rem, nf[2*(NSTG-1-k) +: 2]};
    assign trial = (RMW+2)'({prv.root, 2'b01});

    always_comb begin
      nxt = prv;
      if (cur >= trial) begin
        nxt.rem  = RMW'(cur - trial);
        nxt.root = {prv.root[RTW-2:0], 1'b1};
      end else begin
        nxt.rem  = RMW'(cur);
        nxt.root = {prv.root[RTW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  assign vld_o        = vld_q[NSTG-1];
  assign data_o.side  = st_q[NSTG-1].side;
  assign data_o.q     = st_q[NSTG-1].q;
  assign data_o.degen = (st_q[NSTG-1].n2 == '0);
  assign data_o.nrm   = st_q[NSTG-1].root;

  // a nonzero radicand is at least 2^28, so its root has bit 14 or above set
  `KBC_ASSERT(a_root_floor, clk_i, rst_ni, vld_o && !data_o.degen |-> data_o.nrm[RTW-1:14] != '0)

endmodule

FILE: sv/kbc_qdiv.sv
`include "assert_macros.svh"

module kbc_qdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ce_i,
  input  logic              vld_i,
  input  kbc_pkg::div_in_t  data_i,
  output logic              vld_o,
  output kbc_pkg::cmp_in_t  data_o
);

  localparam int DW    = kbc_pkg::RTW;
  localparam int QUW   = kbc_pkg::QUW;
  localparam int UQW   = kbc_pkg::UQW;
  localparam int RFRAC = kbc_pkg::RFRAC;
  localparam int NW    = UQW + RFRAC;   // dividend width
  localparam int NSTG  = QUW;

  typedef struct packed {
    kbc_pkg::side_t            side;
    logic                      degen;
    logic [DW-1:0]             dv;
    logic [3:0]                neg;
    logic [3:0][DW-1:0]        rem;
    logic [3:0][QUW-1:0]       low;
    logic [3:0][QUW-1:0]       quot;
  } dv_stage_t;

  dv_stage_t        prep_d;
  dv_stage_t        prep_q;
  dv_stage_t        st_q [NSTG];
  logic [UQW-1:0]   mag_w [4];
  logic [NW-1:0]    num_w [4];
  kbc_pkg::cmp_in_t out_d;
  kbc_pkg::cmp_in_t out_q;
  logic [NSTG+1:0]  vld_q;
  logic             uq_ok;

  // dividend = |q| * 2^28 + norm / 2, so the quotient rounds to nearest
  always_comb begin
    prep_d       = '0;
    prep_d.side  = data_i.side;
    prep_d.degen = data_i.degen;
    prep_d.dv    = data_i.nrm;
    for (int i = 0; i < 4; i++) begin
      prep_d.neg[i] = data_i.q[i][kbc_pkg::BW-1];
      mag_w[i] = prep_d.neg[i] ? UQW'(-$signed(data_i.q[i])) : UQW'(data_i.q[i]);
      num_w[i] = {mag_w[i], {RFRAC{1'b0}}} + NW'(data_i.nrm >> 1);
      prep_d.rem[i] = DW'(num_w[i][NW-1:QUW]);
      prep_d.low[i] = num_w[i][QUW-1:0];
    end
  end

  // one quotient bit per stage in each of the four lanes
  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    dv_stage_t     prv;
    dv_stage_t     nxt;
    logic [DW:0]   cur [4];

    if (k == 0) begin : g_first
      assign prv = prep_q;
    end else begin : g_next
      assign prv = st_q[k-1];
    end

    always_comb begin
      nxt = prv;
      for (int i = 0; i < 4; i++) begin
        cur[i] = {prv.rem[i], prv.low[i][QUW-1-k]};
        if (cur[i] >= {1'b0, prv.dv}) begin
          nxt.rem[i]  = DW'(cur[i] - {1'b0, prv.dv});
          nxt.quot[i] = {prv.quot[i][QUW-2:0], 1'b1};
        end else begin
          nxt.rem[i]  = DW'(cur[i]);
          nxt.quot[i] = {prv.quot[i][QUW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  // restore signs, or substitute the identity rotation
  always_comb begin
    out_d.side  = st_q[NSTG-1].side;
    out_d.degen = st_q[NSTG-1].degen;
    for (int i = 0; i < 4; i++) begin
      if (st_q[NSTG-1].degen) begin
        out_d.uq[i] = (i == 3) ? UQW'(kbc_pkg::Q14_ONE) : '0;
      end else if (st_q[NSTG-1].neg[i]) begin
        out_d.uq[i] = -$signed({1'b0, st_q[NSTG-1].quot[i]});
      end else begin
        out_d.uq[i] = $signed({1'b0, st_q[NSTG-1].quot[i]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      prep_q <= prep_d;
      out_q  <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[NSTG:0], vld_i};
    end
  end

  assign vld_o  = vld_q[NSTG+1];
  assign data_o = out_q;

  always_comb begin
    uq_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ($signed(out_q.uq[i]) > 17'sd16400 || $signed(out_q.uq[i]) < -17'sd16400) begin
        uq_ok = 1'b0;
      end
    end
  end

  // normalized components never stray far beyond one
  `KBC_ASSERT_NEVER(a_unit_range, clk_i, rst_ni, vld_o && !data_o.degen && !uq_ok)

endmodule

FILE: sv/kbc_compose.sv
module kbc_compose #(
  parameter int CW = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ce_i,
  input  logic                       vld_i,
  input  kbc_pkg::cmp_in_t           data_i,
  output logic                       vld_o,
  output logic [kbc_pkg::ROW_W-1:0]  row_x_o,
  output logic [kbc_pkg::ROW_W-1:0]  row_y_o,
  output logic [kbc_pkg::ROW_W-1:0]  row_z_o,
  output logic                       degen_o
);

  localparam int RW    = 32;        // rotation entry, 1.0 = 2^28
  localparam int PW    = RW + 17;   // entry times scale
  localparam int ROW_W = kbc_pkg::ROW_W;
  localparam logic signed [35:0] Q28_ONE = 36'sd268435456;
  localparam logic signed [PW-1:0] RND_HALF = PW'(36'sd134217728);
  localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (CW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO = -(PW'(1) <<< (CW - 1));

  function automatic logic [CW-1:0] sat_lane(input logic signed [PW-1:0] v);
    logic [CW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // stage 1: quaternion products xx yy zz xy xz yz xw yw zw
  logic signed [33:0] pr_d [9];
  logic signed [33:0] pr_q [9];
  kbc_pkg::side_t     side1_q;
  logic               dg1_q;

  // stage 2: rotation entries
  logic signed [35:0] e_w [9];
  logic signed [RW-1:0] rot_q [9];
  kbc_pkg::side_t     side2_q;
  logic               dg2_q;

  // stage 3: entries times row scale
  logic signed [PW-1:0] ps_d [9];
  logic signed [PW-1:0] ps_q [9];
  kbc_pkg::side_t     side3_q;
  logic               dg3_q;

  // stage 4: rounded, saturated and packed rows
  logic [ROW_W-1:0]   row_d [3];
  logic [ROW_W-1:0]   row_q [3];
  logic               dg4_q;
  logic [3:0]         vld_q;

  always_comb begin
    pr_d[0] = data_i.uq[0] * data_i.uq[0];
    pr_d[1] = data_i.uq[1] * data_i.uq[1];
    pr_d[2] = data_i.uq[2] * data_i.uq[2];
    pr_d[3] = data_i.uq[0] * data_i.uq[1];
    pr_d[4] = data_i.uq[0] * data_i.uq[2];
    pr_d[5] = data_i.uq[1] * data_i.uq[2];
    pr_d[6] = data_i.uq[0] * data_i.uq[3];
    pr_d[7] = data_i.uq[1] * data_i.uq[3];
    pr_d[8] = data_i.uq[2] * data_i.uq[3];
  end

  always_comb begin
    e_w[0] = Q28_ONE - ((36'(pr_q[1]) + 36'(pr_q[2])) <<< 1);
    e_w[1] = (36'(pr_q[3]) - 36'(pr_q[8])) <<< 1;
    e_w[2] = (36'(pr_q[4]) + 36'(pr_q[7])) <<< 1;
    e_w[3] = (36'(pr_q[3]) + 36'(pr_q[8])) <<< 1;
    e_w[4] = Q28_ONE - ((36'(pr_q[0]) + 36'(pr_q[2])) <<< 1);
    e_w[5] = (36'(pr_q[5]) - 36'(pr_q[6])) <<< 1;
    e_w[6] = (36'(pr_q[4]) - 36'(pr_q[7])) <<< 1;
    e_w[7] = (36'(pr_q[5]) + 36'(pr_q[6])) <<< 1;
    e_w[8] = Q28_ONE - ((36'(pr_q[0]) + 36'(pr_q[1])) <<< 1);
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        ps_d[r*3+j] = rot_q[r*3+j] * $signed(side2_q.scl[r][16:0]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_d[r] = '0;
      for (int j = 0; j < 3; j++) begin
        row_d[r][j*CW +: CW] = sat_lane((ps_q[r*3+j] + RND_HALF) >>> 28);
      end
      row_d[r][3*CW +: CW] = sat_lane(PW'($signed(side3_q.pos[r])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      pr_q    <= pr_d;
      side1_q <= data_i.side;
      dg1_q   <= data_i.degen;
      for (int k = 0; k < 9; k++) begin
        rot_q[k] <= RW'(e_w[k]);
      end
      side2_q <= side1_q;
      dg2_q   <= dg1_q;
      ps_q    <= ps_d;
      side3_q <= side2_q;
      dg3_q   <= dg2_q;
      row_q   <= row_d;
      dg4_q   <= dg3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o   = vld_q[3];
  assign row_x_o = row_q[0];
  assign row_y_o = row_q[1];
  assign row_z_o = row_q[2];
  assign degen_o = dg4_q;

endmodule

FILE: sv/keyframe_blend_trs_compose_unit.sv
// One item per cycle unless the output stalls. The pipeline has 7 blend stages,
// 32 square root stages (one radicand digit pair each), 18 divide stages (a
// dividend stage, one per quotient bit, and an output stage) and 4 matrix
// stages. A stalled output freezes every stage at once.
// Reset clears the valid bits only; the datapath registers are not reset.
`include "assert_macros.svh"

module keyframe_blend_trs_compose_unit #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [kbc_pkg::POS_W-1:0]  pos_a_i,
  input  logic [kbc_pkg::POS_W-1:0]  pos_b_i,
  input  logic [kbc_pkg::ROT_W-1:0]  rot_a_i,
  input  logic [kbc_pkg::ROT_W-1:0]  rot_b_i,
  input  logic [kbc_pkg::SCL_W-1:0]  scale_a_i,
  input  logic [kbc_pkg::SCL_W-1:0]  scale_b_i,
  input  logic [kbc_pkg::T_W-1:0]    blend_t_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [kbc_pkg::ROW_W-1:0]  row_x_o,
  output logic [kbc_pkg::ROW_W-1:0]  row_y_o,
  output logic [kbc_pkg::ROW_W-1:0]  row_z_o,
  output logic                       degenerate_o
);

  localparam int CW = COMP_WIDTH;

  // Pipeline advance: every stage moves unless a finished result is held
  // at the output by the consumer. Bubbles move along with the data, so
  // an input transfer can happen in any cycle the output is free.
  logic              ce;
  logic              blend_vld;
  logic              sqrt_vld;
  logic              div_vld;
  kbc_pkg::nrm_in_t  blend_data;
  kbc_pkg::div_in_t  sqrt_data;
  kbc_pkg::cmp_in_t  div_data;
  logic              offdiag_zero;

  assign in_stall_o = out_valid_o & out_stall_i;
  assign ce         = ~in_stall_o;

  // Front end: lane extraction, factor clamp, dot sign, three lerps and
  // the squared norm of the blended quaternion.
  kbc_blend #(
    .CW(CW)
  ) u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ce_i      (ce),
    .vld_i     (in_valid_i),
    .pos_a_i   (pos_a_i),
    .pos_b_i   (pos_b_i),
    .rot_a_i   (rot_a_i),
    .rot_b_i   (rot_b_i),
    .scale_a_i (scale_a_i),
    .scale_b_i (scale_b_i),
    .blend_t_i (blend_t_i),
    .vld_o     (blend_vld),
    .data_o    (blend_data)
  );

  // Norm: floor square root of n2 * 2^28, which is the norm in Q.28.
  kbc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .vld_i  (blend_vld),
    .data_i (blend_data),
    .vld_o  (sqrt_vld),
    .data_o (sqrt_data)
  );

  // Normalize: four rounded divides by the norm, identity on a zero norm.
  kbc_qdiv u_qdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .vld_i  (sqrt_vld),
    .data_i (sqrt_data),
    .vld_o  (div_vld),
    .data_o (div_data)
  );

  // Rotation matrix, row scaling, saturation and packing; the last stage
  // is the output register.
  kbc_compose #(
    .CW(CW)
  ) u_compose (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .vld_i   (div_vld),
    .data_i  (div_data),
    .vld_o   (out_valid_o),
    .row_x_o (row_x_o),
    .row_y_o (row_y_o),
    .row_z_o (row_z_o),
    .degen_o (degenerate_o)
  );

  assign offdiag_zero = (row_x_o[CW +: 2*CW] == '0) && (row_y_o[0 +: CW] == '0) &&
                        (row_y_o[2*CW +: CW] == '0) && (row_z_o[0 +: 2*CW] == '0);

  // identity rotation leaves every off-diagonal entry at zero
  `KBC_ASSERT(a_degen_offdiag, clk_i, rst_ni, out_valid_o && degenerate_o |-> offdiag_zero)

endmodule

FILE: bench/tb_keyframe_blend_trs_compose_unit.sv
`timescale 1ns / 100ps

module tb_keyframe_blend_trs_compose_unit;

  localparam int CW = 16;

  // one keyframe pair plus blend factor
  typedef struct {
    logic [kbc_pkg::POS_W-1:0] pa, pb;
    logic [kbc_pkg::ROT_W-1:0] ra, rb;
    logic [kbc_pkg::SCL_W-1:0] sa, sb;
    logic [kbc_pkg::T_W-1:0]   t;
  } key_pair_t;

  // one composed matrix
  typedef struct {
    logic [kbc_pkg::ROW_W-1:0] rx, ry, rz;
    logic                      degen;
  } trs_mat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [kbc_pkg::POS_W-1:0] pos_a = '0, pos_b = '0;
  logic [kbc_pkg::ROT_W-1:0] rot_a = '0, rot_b = '0;
  logic [kbc_pkg::SCL_W-1:0] scale_a = '0, scale_b = '0;
  logic [kbc_pkg::T_W-1:0]   blend_t = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [kbc_pkg::ROW_W-1:0] row_x, row_y, row_z;
  logic degenerate;

  key_pair_t pending_keys[$];
  trs_mat_t  matrix_due[$];
  int        mismatches = 0;
  int        cycle_cnt = 0;
  bit        stim_done = 1'b0;

  keyframe_blend_trs_compose_unit #(.COMP_WIDTH(CW)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_a_i(pos_a), .pos_b_i(pos_b), .rot_a_i(rot_a), .rot_b_i(rot_b),
    .scale_a_i(scale_a), .scale_b_i(scale_b), .blend_t_i(blend_t),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .row_x_o(row_x), .row_y_o(row_y), .row_z_o(row_z),
    .degenerate_o(degenerate)
  );

  always #5 clk = ~clk;

  // signed lane k of a packed vector
  function automatic longint lane_of(logic [63:0] v, int k);
    logic [CW-1:0] u;
    u = v[k*CW +: CW];
    return longint'($signed(u));
  endfunction

  // floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return a + round_shift((b - a) * t, 15);
  endfunction

  function automatic longint clamp_lane(longint v);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -(longint'(1) << (CW - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic trs_mat_t compose_matrix(key_pair_t k);
    trs_mat_t m;
    longint t, dot, pos[3], scl[3], qa[4], qb[4], q[4], rot[3][3], r;
    longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
    longint unsigned n2, nrm, mag;
    logic [63:0] row;
    t = longint'(k.t);
    if (t > 32768) t = 32768;
    for (int i = 0; i < 3; i++) begin
      pos[i] = lerp(lane_of(64'(k.pa), i), lane_of(64'(k.pb), i), t);
      scl[i] = lerp(lane_of(64'(k.sa), i), lane_of(64'(k.sb), i), t);
    end
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      qa[i] = lane_of(k.ra, i);
      qb[i] = lane_of(k.rb, i);
      dot += qa[i] * qb[i];
    end
    n2 = 0;
    for (int i = 0; i < 4; i++) begin
      if (dot < 0) qa[i] = -qa[i];
      q[i] = lerp(qa[i], qb[i], t);
      n2 += longint'(q[i] * q[i]);
    end
    m.degen = (n2 == 0);
    if (m.degen) begin
      q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 16384;
    end else begin
      nrm = int_sqrt(n2 << 28);
      for (int i = 0; i < 4; i++) begin
        mag = (q[i] < 0) ? -q[i] : q[i];
        r = longint'(((mag << 28) + nrm / 2) / nrm);
        q[i] = (q[i] < 0) ? -r : r;
      end
    end
    xx = q[0]*q[0]; yy = q[1]*q[1]; zz = q[2]*q[2];
    xy = q[0]*q[1]; xz = q[0]*q[2]; yz = q[1]*q[2];
    xw = q[0]*q[3]; yw = q[1]*q[3]; zw = q[2]*q[3];
    rot[0][0] = (longint'(1) << 28) - 2*(yy + zz);
    rot[0][1] = 2*(xy - zw);
    rot[0][2] = 2*(xz + yw);
    rot[1][0] = 2*(xy + zw);
    rot[1][1] = (longint'(1) << 28) - 2*(xx + zz);
    rot[1][2] = 2*(yz - xw);
    rot[2][0] = 2*(xz - yw);
    rot[2][1] = 2*(yz + xw);
    rot[2][2] = (longint'(1) << 28) - 2*(xx + yy);
    for (int i = 0; i < 3; i++) begin
      row = '0;
      for (int j = 0; j < 3; j++)
        row[j*CW +: CW] = CW'(clamp_lane(round_shift(rot[i][j] * scl[i], 28)));
      row[3*CW +: CW] = CW'(clamp_lane(pos[i]));
      if (i == 0) m.rx = row;
      else if (i == 1) m.ry = row;
      else m.rz = row;
    end
    return m;
  endfunction

  // no idling in a window of the run, else idle with a probability of 35 percent
  function automatic bit idle_now();
    if (cycle_cnt > 1500 && cycle_cnt < 2300) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  // driver: advance to the next keyframe pair only once the current one transfers
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_keys.size() != 0 && !idle_now()) begin
        key_pair_t k;
        k = pending_keys.pop_front();
        matrix_due.push_back(compose_matrix(k));
        in_valid <= 1'b1;
        pos_a <= k.pa; pos_b <= k.pb;
        rot_a <= k.ra; rot_b <= k.rb;
        scale_a <= k.sa; scale_b <= k.sb;
        blend_t <= k.t;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each output transfer against the oldest predicted matrix
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (matrix_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output transfer");
        end else begin
          trs_mat_t e;
          e = matrix_due.pop_front();
          if (e.rx !== row_x || e.ry !== row_y || e.rz !== row_z ||
              e.degen !== degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                       e.rx, e.ry, e.rz, e.degen, row_x, row_y, row_z, degenerate);
          end
        end
      end
      out_stall <= idle_now();
    end
  end

  function automatic logic [15:0] rand_q14();
    case ($urandom_range(3))
      0: return 16'($urandom_range(32767) - 16384) ;
      1: return 16'($urandom_range(65535));
      2: return 16'($urandom_range(8) - 4);
      default: return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  function automatic logic [kbc_pkg::T_W-1:0] rand_blend();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return kbc_pkg::T_ONE;
      2: return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic key_pair_t rand_keys();
    key_pair_t k;
    k.pa = 48'({$urandom(), $urandom()});
    k.pb = 48'({$urandom(), $urandom()});
    for (int i = 0; i < 4; i++) begin
      k.ra[i*16 +: 16] = rand_q14();
      k.rb[i*16 +: 16] = rand_q14();
    end
    if ($urandom_range(3) == 0) begin
      k.sa = 48'({$urandom(), $urandom()});
      k.sb = 48'({$urandom(), $urandom()});
    end else begin
      for (int i = 0; i < 3; i++) begin
        k.sa[i*16 +: 16] = 16'($urandom_range(12288));
        k.sb[i*16 +: 16] = 16'($urandom_range(12288));
      end
    end
    k.t = rand_blend();
    return k;
  endfunction

  task automatic add_keys(logic [63:0] ra, logic [63:0] rb, logic [47:0] p,
                          logic [47:0] s, logic [kbc_pkg::T_W-1:0] t);
    key_pair_t k;
    k.pa = p; k.pb = ~p; k.ra = ra; k.rb = rb;
    k.sa = s; k.sb = s; k.t = t;
    pending_keys.push_back(k);
  endtask

  initial begin
    localparam logic [63:0] Q_ID  = 64'h4000_0000_0000_0000;
    localparam logic [47:0] S_ONE = 48'h1000_1000_1000;
    // blend factor at both ends, just below one, and clamped above one
    add_keys(Q_ID, 64'h0000_0000_0000_4000, 48'h0100_0200_0300, S_ONE, 16'h0000);
    add_keys(Q_ID, 64'h2d41_0000_0000_2d41, 48'h0100_0200_0300, S_ONE, kbc_pkg::T_ONE);
    add_keys(Q_ID, 64'h2d41_0000_2d41_0000, 48'h7fff_8000_0000, S_ONE, 16'h7fff);
    add_keys(Q_ID, 64'h0000_2d41_0000_2d41, 48'h8000_7fff_ffff, S_ONE, 16'hffff);
    add_keys(Q_ID, 64'h0000_2d41_0000_2d41, 48'h0000_0000_0000, S_ONE, 16'h8001);
    // zero quaternions: identity with the degenerate flag
    add_keys('0, '0, 48'h1234_5678_9abc, S_ONE, 16'h4000);
    add_keys('0, Q_ID, 48'h1234_5678_9abc, S_ONE, 16'h0000);
    // opposite keys: negate the first, including the most negative lane
    add_keys(64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff, '0, S_ONE, 16'h4000);
    add_keys(64'hc000_0000_0000_0000, Q_ID, '0, S_ONE, 16'h2000);
    add_keys(64'hffff_ffff_ffff_ffff, 64'h0001_0001_0001_0001, '0, S_ONE, 16'h6000);
    // saturating scales and positions
    add_keys(Q_ID, Q_ID, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 16'h4000);
    add_keys(Q_ID, 64'h2d41_2d41_0000_0000, 48'h8000_8000_8000, 48'h8000_8000_8000,
             16'h4000);
    add_keys(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
             48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 16'hffff);
    add_keys(64'h0001_0000_0000_0000, 64'h0000_0000_0001_0000, '0, S_ONE, 16'h4000);
    for (int i = 0; i < 1250; i++) pending_keys.push_back(rand_keys());

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_keys.size() == 0 && matrix_due.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && matrix_due.size() == 0)
      $display("keyframe_blend_trs_compose_unit regression: pass");
    else
      $display("keyframe_blend_trs_compose_unit regression: fail");
    $finish;
  end

  // hold a hard stop well past the slowest correct run
  initial begin
    #2000000;
    $display("keyframe_blend_trs_compose_unit regression: fail");
    $finish;
  end

endmodule

FILE: keyframe_blend_trs_compose_unit.f
+incdir+sv
sv/kbc_pkg.sv
sv/kbc_blend.sv
sv/kbc_isqrt.sv
sv/kbc_qdiv.sv
sv/kbc_compose.sv
sv/keyframe_blend_trs_compose_unit.sv
bench/tb_keyframe_blend_trs_compose_unit.sv
